FILE: rtl/core/descending_sorted_list_top_defines.svh
`ifndef DESCENDING_SORTED_LIST_TOP_DEFINES_SVH
`define DESCENDING_SORTED_LIST_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DSL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dsl_pkg.sv
package dsl_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               status;
		logic [4:0]               entry_count;
		logic [4:0]               removed_count;
		logic signed [DATA_W-1:0] read_value;
	} result_t;

endpackage

FILE: rtl/core/dsl_mem.sv
module dsl_mem #(
	parameter int DEPTH = dsl_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(DEPTH)-1:0]          wr_addr,
	input  logic signed [dsl_pkg::DATA_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [$clog2(DEPTH)-1:0]          rd_addr,
	output logic signed [dsl_pkg::DATA_W-1:0] rd_data
);

	logic signed [dsl_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/dsl_seq.sv
`include "descending_sorted_list_top_defines.svh"

module dsl_seq #(
	parameter int DEPTH = dsl_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        in_cmd,
	input  logic signed [dsl_pkg::DATA_W-1:0] in_value,
	input  logic [3:0]                        in_pos,
	output logic                              res_valid,
	input  logic                              res_ready,
	output dsl_pkg::result_t                  res,
	output logic                              mem_wr_en,
	output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
	output logic signed [dsl_pkg::DATA_W-1:0] mem_wr_data,
	output logic                              mem_rd_en,
	output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
	input  logic signed [dsl_pkg::DATA_W-1:0] mem_rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_START   = 3'd1;
	localparam logic [2:0] S_INS_CHK = 3'd2;
	localparam logic [2:0] S_DEL_CHK = 3'd3;
	localparam logic [2:0] S_RD_CHK  = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]                        state_q;
	logic [CW-1:0]                     held_q;
	logic [1:0]                        cmd_q;
	logic signed [dsl_pkg::DATA_W-1:0] val_q;
	logic [3:0]                        pos_q;
	logic [CW-1:0]                     ptr_q;
	logic [AW-1:0]                     rdi_q;
	logic [CW-1:0]                     wri_q;
	logic [CW-1:0]                     rem_q;
	logic [1:0]                        status_q;
	logic signed [dsl_pkg::DATA_W-1:0] rdval_q;

	logic is_full;
	logic is_empty;
	logic pos_hit;
	logic ins_stop;
	logic del_match;
	logic del_last;

	assign is_full   = (held_q == CW'(DEPTH));
	assign is_empty  = (held_q == '0);
	assign pos_hit   = (32'(pos_q) < 32'(held_q)) && (32'(pos_q) < 32'(DEPTH));
	assign ins_stop  = (ptr_q == '0) || (mem_rd_data > val_q);
	assign del_match = (mem_rd_data == val_q);
	assign del_last  = ((CW'(rdi_q) + CW'(1)) == held_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign res.status        = status_q;
	assign res.entry_count   = 5'(held_q);
	assign res.removed_count = 5'(rem_q);
	assign res.read_value    = rdval_q;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = val_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		case (state_q)
			S_START: begin
				case (cmd_q)
					dsl_pkg::CMD_INSERT: begin
						if (is_empty) begin
							mem_wr_en = 1'b1;
						end else if (!is_full) begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = AW'(held_q - CW'(1));
						end
					end
					dsl_pkg::CMD_DELETE: begin
						mem_rd_en = !is_empty;
					end
					dsl_pkg::CMD_READ: begin
						mem_rd_en   = pos_hit;
						mem_rd_addr = AW'(pos_q);
					end
					default: ;
				endcase
			end
			S_INS_CHK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = AW'(ptr_q);
				if (!ins_stop) begin
					mem_wr_data = mem_rd_data;
					if (ptr_q > CW'(1)) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = AW'(ptr_q - CW'(2));
					end
				end
			end
			S_DEL_CHK: begin
				mem_wr_en   = !del_match;
				mem_wr_addr = AW'(wri_q);
				mem_wr_data = mem_rd_data;
				if (!del_last) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = rdi_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					case (cmd_q)
						dsl_pkg::CMD_INSERT: begin
							if (is_full) begin
								state_q <= S_DONE;
							end else if (is_empty) begin
								held_q  <= CW'(1);
								state_q <= S_DONE;
							end else begin
								state_q <= S_INS_CHK;
							end
						end
						dsl_pkg::CMD_DELETE: begin
							state_q <= is_empty ? S_DONE : S_DEL_CHK;
						end
						dsl_pkg::CMD_READ: begin
							state_q <= pos_hit ? S_RD_CHK : S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_INS_CHK: begin
					if (ins_stop) begin
						held_q  <= held_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DEL_CHK: begin
					if (del_last) begin
						held_q  <= del_match ? wri_q : wri_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_RD_CHK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= in_cmd;
				val_q <= in_value;
				pos_q <= in_pos;
			end
			S_START: begin
				status_q <= dsl_pkg::ST_OK;
				rem_q    <= '0;
				rdval_q  <= '0;
				ptr_q    <= held_q;
				rdi_q    <= '0;
				wri_q    <= '0;
				if (cmd_q == dsl_pkg::CMD_INSERT && is_full) begin
					status_q <= dsl_pkg::ST_FULL;
				end
				if (cmd_q == dsl_pkg::CMD_READ && !pos_hit) begin
					status_q <= dsl_pkg::ST_EMPTY;
				end
			end
			S_INS_CHK: begin
				if (!ins_stop) begin
					ptr_q <= ptr_q - CW'(1);
				end
			end
			S_DEL_CHK: begin
				if (del_match) begin
					rem_q <= rem_q + CW'(1);
				end else begin
					wri_q <= wri_q + CW'(1);
				end
				rdi_q <= rdi_q + AW'(1);
			end
			S_RD_CHK: begin
				rdval_q <= mem_rd_data;
			end
			default: ;
		endcase
	end

	`DSL_ASSERT_NOW(a_no_port_clash, clk, arst_n, mem_rd_en && mem_wr_en,
		mem_rd_addr != mem_wr_addr, "read and write hit the same entry")
	`DSL_ASSERT_NOW(a_held_bound, clk, arst_n, 1'b1, held_q <= CW'(DEPTH),
		"entry count above depth")
	`DSL_ASSERT_NOW(a_full_no_write, clk, arst_n,
		state_q == S_START && cmd_q == dsl_pkg::CMD_INSERT && is_full,
		!mem_wr_en && !mem_rd_en, "full insert touched memory")
	`DSL_ASSERT_NOW(a_compact_order, clk, arst_n, state_q == S_DEL_CHK,
		wri_q <= CW'(rdi_q), "compaction write ahead of read")
	`DSL_ASSERT_NEXT(a_read_no_count, clk, arst_n,
		state_q == S_START && cmd_q == dsl_pkg::CMD_READ,
		$stable(held_q), "read changed entry count")

endmodule

FILE: rtl/core/descending_sorted_list_top.sv
// channel  role    tvalid/tready       tdata (low bit up)                    tuser
// s_*      input   s_tvalid/s_tready   value[31:0], position[35:32]          command[1:0]
// m_*      output  m_tvalid/m_tready   entry_count[4:0], removed_count[9:5],  status[1:0]
//                                      read_value[41:10]
// A beat is accepted in S_IDLE, dispatched in S_START and passed to the output register in S_DONE.
// An insert into a store neither empty nor full scans from the last entry towards the first,
// moving each entry at or below the new value up one place; delete scans every held entry;
// a read that hits reads its entry in S_RD_CHK. The single memory read port sets the scan pace.
// Reset clears the entry count and all valid flags; memory contents need no clearing.
// A result waiting on m_tready stalls the next beat only once its own work is finished.
module descending_sorted_list_top #(
	parameter int DEPTH = dsl_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[35:32], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // entry_count[4:0], removed_count[9:5], read_value[41:10]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = $clog2(DEPTH);

	logic                              res_valid;
	logic                              res_ready;
	dsl_pkg::result_t                  res;
	logic                              mem_wr_en;
	logic [AW-1:0]                     mem_wr_addr;
	logic signed [dsl_pkg::DATA_W-1:0] mem_wr_data;
	logic                              mem_rd_en;
	logic [AW-1:0]                     mem_rd_addr;
	logic signed [dsl_pkg::DATA_W-1:0] mem_rd_data;
	logic                              out_valid_q;
	dsl_pkg::result_t                  out_q;

	dsl_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (s_tuser),
		.in_value    (s_tdata[31:0]),
		.in_pos      (s_tdata[35:32]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	dsl_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {6'd0, out_q.read_value, out_q.removed_count, out_q.entry_count};

endmodule

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH      = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	logic signed [31:0] sorted_vals [0:DEPTH-1];
	int                 n_held;
	dsl_pkg::result_t   pending_results [$];
	int                 err_count;
	bit                 src_gaps;
	bit                 sink_gaps;
	int                 sink_hold;
	int                 sink_gap;

	descending_sorted_list_top #(.DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic dsl_pkg::result_t apply_cmd(logic [1:0] cmd, logic signed [31:0] val,
			logic [3:0] pos);
		dsl_pkg::result_t r;
		int               at;
		int               kept;
		int               gone;
		int               i;
		r    = '0;
		gone = 0;
		case (cmd)
			dsl_pkg::CMD_INSERT: begin
				if (n_held >= DEPTH) begin
					r.status = dsl_pkg::ST_FULL;
				end else begin
					at = n_held;
					for (i = 0; i < n_held; i++) begin
						if (sorted_vals[i] <= val) begin
							at = i;
							break;
						end
					end
					for (i = n_held; i > at; i--)
						sorted_vals[i] = sorted_vals[i-1];
					sorted_vals[at] = val;
					n_held++;
				end
			end
			dsl_pkg::CMD_DELETE: begin
				kept = 0;
				for (i = 0; i < n_held; i++) begin
					if (sorted_vals[i] == val) begin
						gone++;
					end else begin
						sorted_vals[kept] = sorted_vals[i];
						kept++;
					end
				end
				n_held = kept;
			end
			dsl_pkg::CMD_READ: begin
				if (pos < n_held)
					r.read_value = sorted_vals[pos];
				else
					r.status = dsl_pkg::ST_EMPTY;
			end
			default: ;
		endcase
		r.entry_count   = 5'(n_held);
		r.removed_count = 5'(gone);
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value(bit from_store);
		int r;
		r = $urandom_range(0, 9);
		if (from_store && n_held > 0 && r < 5)
			return sorted_vals[$urandom_range(0, n_held - 1)];
		if (r < 7)
			return $urandom_range(0, 6) - 3;
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 32'sh0000_0000;
				default: return 32'shFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin : result_check
		dsl_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				if (m_tdata[4:0] != want.entry_count)
					report_mismatch("entry_count", 32'(m_tdata[4:0]),
						32'(want.entry_count));
				if (m_tdata[9:5] != want.removed_count)
					report_mismatch("removed_count", 32'(m_tdata[9:5]),
						32'(want.removed_count));
				if (m_tdata[41:10] != want.read_value)
					report_mismatch("read_value", m_tdata[41:10], want.read_value);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(1, 13) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_beat(logic [1:0] cmd, logic signed [31:0] val, logic [3:0] pos);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, pos, val};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_cmd(cmd, val, pos));
	endtask

	task automatic random_beat(int ins_pct, int del_pct);
		int         roll;
		logic [1:0] cmd;
		logic [3:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			cmd = dsl_pkg::CMD_INSERT;
		else if (roll < ins_pct + del_pct)
			cmd = dsl_pkg::CMD_DELETE;
		else if (roll < 98)
			cmd = dsl_pkg::CMD_READ;
		else
			cmd = CMD_UNUSED;
		if (n_held > 0 && $urandom_range(0, 3) != 0)
			pos = 4'($urandom_range(0, n_held - 1));
		else
			pos = 4'($urandom_range(0, 15));
		send_beat(cmd, pick_value(cmd != dsl_pkg::CMD_READ), pos);
	endtask

	task automatic test_directed();
		send_beat(CMD_UNUSED, 32'sh0, 4'd0);
		send_beat(dsl_pkg::CMD_READ, 32'sh0, 4'd0);
		send_beat(dsl_pkg::CMD_DELETE, 32'sh5, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'sh8000_0000, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'sh0, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'shFFFF_FFFF, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'sh0, 4'd0);
		send_beat(dsl_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 4'd0);
		for (int p = 0; p < 7; p++)
			send_beat(dsl_pkg::CMD_READ, 32'sh0, 4'(p));
		send_beat(dsl_pkg::CMD_READ, 32'shFFFF_FFFF, 4'd15);
		send_beat(dsl_pkg::CMD_DELETE, 32'sh0, 4'd0);
		send_beat(dsl_pkg::CMD_DELETE, 32'sh5, 4'd0);
		send_beat(dsl_pkg::CMD_DELETE, 32'sh7FFF_FFFF, 4'd0);
		send_beat(CMD_UNUSED, 32'shFFFF_FFFF, 4'd15);
		send_beat(dsl_pkg::CMD_READ, 32'sh0, 4'd1);
	endtask

	task automatic test_fill_and_drain();
		repeat (6) begin
			repeat (60) random_beat(70, 5);
			repeat (40) random_beat(10, 50);
		end
	endtask

	task automatic test_backpressure();
		src_gaps  = 1'b0;
		sink_hold = 300;
		repeat (40) random_beat(50, 10);
		src_gaps  = 1'b1;
	endtask

	task automatic test_random_mix();
		repeat (900) random_beat(45, 15);
	endtask

	task automatic test_steady_stream();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		repeat (300) random_beat(45, 15);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		n_held    = 0;
		err_count = 0;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		sink_hold = 0;
		sink_gap  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random_mix();
		test_steady_stream();
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: descending_sorted_list_top.f
+incdir+rtl/core
rtl/core/dsl_pkg.sv
rtl/core/dsl_mem.sv
rtl/core/dsl_seq.sv
rtl/core/descending_sorted_list_top.sv
tb/tb_top.sv
